// File: hw/rtl/pli_pkg.sv
// Package with the constants, codes and handshake structs of the positional list.
`default_nettype none
package pli_pkg;

  // List depth and derived widths.
  localparam int DEPTH   = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int POS_W   = 7;
  localparam int VALUE_W = 32;

  // Operation codes of an input beat.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Status codes of a result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ONE,
    S_DUMP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // apply the accepted operation
    logic idx_inc;   // advance the dump index
    logic sel_dump;  // result beat carries a list entry
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dump_go;   // accepted beat is a dump of a non-empty list
    logic idx_last;  // dump index points at the final entry
  } sts_t;

endpackage
`default_nettype wire

// File: hw/rtl/pli_ctrl.sv
// Controller state machine of the positional list.
`default_nettype none
module pli_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  input  wire pli_pkg::sts_t sts_i,
  output pli_pkg::cmd_t     cmd_o
);
  import pli_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.dump_go ? S_DUMP : S_ONE;
        end
      end
      S_ONE: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (!out_stall_i && sts_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_stall_o       = 1'b1;
    out_valid_o      = 1'b0;
    cmd_o.load       = 1'b0;
    cmd_o.idx_inc    = 1'b0;
    cmd_o.sel_dump   = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_ONE: begin
        out_valid_o = 1'b1;
      end
      S_DUMP: begin
        out_valid_o    = 1'b1;
        cmd_o.sel_dump = 1'b1;
        cmd_o.idx_inc  = !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/pli_dp.sv
// Datapath of the positional list: shifting entry cells, count and result fields.
`default_nettype none
module pli_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [1:0]                      op_i,
  input  wire logic [pli_pkg::POS_W-1:0]       position_i,
  input  wire logic signed [pli_pkg::VALUE_W-1:0] value_i,
  input  wire pli_pkg::cmd_t                   cmd_i,
  output pli_pkg::sts_t                        sts_o,
  output logic [1:0]                           status_o,
  output logic signed [pli_pkg::VALUE_W-1:0]   entry_value_o,
  output logic [pli_pkg::POS_W-1:0]            entry_position_o,
  output logic [pli_pkg::POS_W-1:0]            count_now_o,
  output logic                                 last_o
);
  import pli_pkg::*;

  logic signed [VALUE_W-1:0] cell_q [DEPTH];
  logic signed [VALUE_W-1:0] cell_d [DEPTH];
  logic signed [VALUE_W-1:0] prev_w [DEPTH];
  logic signed [VALUE_W-1:0] next_w [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  status_e          status_q, status_d;
  op_e              op_w;
  logic [POS_W-1:0] cnt_ext;
  logic [IDX_W-1:0] pos_idx;
  logic             full_w, ins_range, del_range, do_ins, do_del;

  // Decode the operation against the current count.
  always_comb begin
    op_w      = op_e'(op_i);
    cnt_ext   = POS_W'(count_q);
    pos_idx   = IDX_W'(position_i - POS_W'(1));
    full_w    = (count_q == CNT_W'(DEPTH));
    ins_range = (position_i == '0) || (position_i > POS_W'(cnt_ext + POS_W'(1)));
    del_range = (position_i == '0) || (position_i > cnt_ext);
    do_ins    = cmd_i.load && (op_w == OP_INSERT) && !full_w && !ins_range;
    do_del    = cmd_i.load && (op_w == OP_DELETE) && !del_range;
    sts_o.dump_go  = (op_w == OP_DUMP) && (count_q != '0);
    sts_o.idx_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  end

  // Neighbor taps for the parallel shift; the ends take the new value or hold.
  always_comb begin
    prev_w[0]       = value_i;
    next_w[DEPTH-1] = cell_q[DEPTH-1];
    for (int j = 1; j < DEPTH; j++) begin
      prev_w[j] = cell_q[j-1];
    end
    for (int j = 0; j < DEPTH - 1; j++) begin
      next_w[j] = cell_q[j+1];
    end
  end

  // Each cell at or above the position shifts up on insert and down on delete.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      cell_d[j] = cell_q[j];
      if (do_ins && (IDX_W'(j) >= pos_idx)) begin
        cell_d[j] = (IDX_W'(j) == pos_idx) ? value_i : prev_w[j];
      end else if (do_del && (IDX_W'(j) >= pos_idx)) begin
        cell_d[j] = next_w[j];
      end
    end
  end

  // Count, status and dump index.
  always_comb begin
    count_d  = count_q;
    status_d = status_q;
    idx_d    = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
      case (op_w)
        OP_INSERT: begin
          if (full_w) begin
            status_d = ST_FULL;
          end else if (ins_range) begin
            status_d = ST_RANGE;
          end else begin
            status_d = ST_OK;
            count_d  = count_q + CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (del_range) begin
            status_d = ST_RANGE;
          end else begin
            status_d = ST_OK;
            count_d  = count_q - CNT_W'(1);
          end
        end
        OP_DUMP: begin
          status_d = (count_q == '0) ? ST_EMPTY : ST_OK;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  // Entry cells hold payload only and need no reset.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH; j++) begin
      cell_q[j] <= cell_d[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
      idx_q    <= '0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      idx_q    <= idx_d;
    end
  end

  // Result beat fields.
  always_comb begin
    count_now_o = cnt_ext;
    if (cmd_i.sel_dump) begin
      status_o         = ST_OK;
      entry_value_o    = cell_q[idx_q];
      entry_position_o = POS_W'(idx_q) + POS_W'(1);
      last_o           = sts_o.idx_last;
    end else begin
      status_o         = status_q;
      entry_value_o    = '0;
      entry_position_o = '0;
      last_o           = 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/positional_list_insert_delete_top.sv
// Top level of the positional list: controller and datapath.
// Insert, delete and other single-result beats: accepted while idle, result
// beat valid the next cycle, next input beat taken the cycle after it leaves.
// A dump of a non-empty list with N entries gives N result beats, one per cycle without stall,
// set by the dump index that walks the entry cells.
// Reset (asynchronous, active low) empties the list; the cells keep no reset.
`default_nettype none
module positional_list_insert_delete_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [1:0]                          op_i,
  input  wire logic [pli_pkg::POS_W-1:0]           position_i,
  input  wire logic signed [pli_pkg::VALUE_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [1:0]                               status_o,
  output logic signed [pli_pkg::VALUE_W-1:0]       entry_value_o,
  output logic [pli_pkg::POS_W-1:0]                entry_position_o,
  output logic [pli_pkg::POS_W-1:0]                count_now_o,
  output logic                                     last_o
);
  import pli_pkg::*;

  cmd_t cmd_w;
  sts_t sts_w;

  // Sequencing of beats.
  pli_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts_w),
    .cmd_o       (cmd_w)
  );

  // List storage and result fields.
  pli_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .cmd_i            (cmd_w),
    .sts_o            (sts_w),
    .status_o         (status_o),
    .entry_value_o    (entry_value_o),
    .entry_position_o (entry_position_o),
    .count_now_o      (count_now_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire
